### sv/word_stream_can_fd_framer_defines.svh
// Assertion macros for the word stream CAN-FD framer.
// Included by the RTL files that carry concurrent assertions; needs aclk and aresetn in scope.
`ifndef WORD_STREAM_CAN_FD_FRAMER_DEFINES_SVH
`define WORD_STREAM_CAN_FD_FRAMER_DEFINES_SVH

`ifndef SYNTH
`define WSCF_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("wscf: same-cycle check failed");
`define WSCF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("wscf: next-cycle check failed");
`else
`define WSCF_ASSERT_IMPL(label, ante, cons)
`define WSCF_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### sv/wscf_pkg.sv
// Shared constants and types of the word stream CAN-FD framer.
// Used by every module of the block; depends on nothing.
package wscf_pkg;

    localparam int MAX_FRAMES      = 16;
    localparam int WORDS_PER_FRAME = 31;
    localparam int PAYLOAD_BYTES   = 64;

    localparam int WORD_W = 16;
    localparam int BYTE_W = 8;
    localparam int POS_W  = $clog2(PAYLOAD_BYTES);
    localparam int FNUM_W = 5;
    localparam int WIF_W  = 5;
    localparam int FC_W   = $clog2(MAX_FRAMES + 1);
    localparam int HDR_W  = 16;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(PAYLOAD_BYTES - 1);

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last_word;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } hold_t;

endpackage

### sv/wscf_in_stage.sv
// Input holding register of the word stream CAN-FD framer.
// Depends on wscf_pkg; feeds wscf_byte_gen.
module wscf_in_stage (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [wscf_pkg::WORD_W-1:0]  s_tdata,   // word
    input  logic                         s_tlast,   // last_word
    output wscf_pkg::hold_t              hold,
    input  logic                         take
);
    import wscf_pkg::*;

    logic  valid_reg, valid_next;
    item_t item_reg;

    assign s_tready = !valid_reg || take;
    assign hold     = '{valid: valid_reg, item: item_reg};

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (s_tvalid && s_tready) begin
            item_reg <= '{word: s_tdata, last_word: s_tlast};
        end
    end

endmodule

### sv/wscf_byte_gen.sv
// Framing state, byte sequencer and output register of the word stream CAN-FD framer.
// Depends on wscf_pkg and word_stream_can_fd_framer_defines.svh; fed by wscf_in_stage.
module wscf_byte_gen (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  wscf_pkg::hold_t       hold,
    output logic                  take,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,   // frame_byte, byte_position, frame_number
    output logic                  m_tlast,   // frame_end
    output logic                  m_tuser    // run_end
);
    import wscf_pkg::*;
    `include "word_stream_can_fd_framer_defines.svh"

    logic [FC_W-1:0]   fc_reg, fc_next;
    logic [WIF_W-1:0]  wif_reg, wif_next;
    logic              busy_reg, busy_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  end_reg, end_next;
    logic [POS_W-1:0]  wpos_reg, wpos_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic [HDR_W-1:0]  hdr_reg, hdr_next;
    logic [FNUM_W-1:0] fnum_reg, fnum_next;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [BYTE_W-1:0] m_byte_reg;
    logic [POS_W-1:0]  m_pos_reg;
    logic [FNUM_W-1:0] m_fnum_reg;
    logic              m_tlast_reg;
    logic              m_tuser_reg;

    logic              emit, finishing;
    logic              open_frame, drop, closing;
    logic [FC_W-1:0]   fc_inc, fc_item;
    logic [WIF_W-1:0]  wif_inc;
    logic [POS_W-1:0]  wpos;
    logic [BYTE_W-1:0] byte_sel;

    assign emit      = busy_reg && (!m_tvalid_reg || m_tready);
    assign finishing = emit && (pos_reg == end_reg);
    assign take      = hold.valid && (!busy_reg || finishing);

    assign open_frame = (wif_reg == '0);
    assign drop       = open_frame && (fc_reg >= FC_W'(MAX_FRAMES));
    assign fc_inc     = fc_reg + FC_W'(1);
    assign fc_item    = open_frame ? fc_inc : fc_reg;
    assign wif_inc    = wif_reg + WIF_W'(1);
    assign closing    = hold.item.last_word || (wif_inc >= WIF_W'(WORDS_PER_FRAME));
    assign wpos       = POS_W'({wif_reg, 1'b0}) + POS_W'(2);

    always_comb begin
        priority if (pos_reg == POS_W'(0)) begin
            byte_sel = hdr_reg[HDR_W-1 -: BYTE_W];
        end else if (pos_reg == POS_W'(1)) begin
            byte_sel = hdr_reg[BYTE_W-1:0];
        end else if (pos_reg == wpos_reg) begin
            byte_sel = word_reg[WORD_W-1 -: BYTE_W];
        end else if (pos_reg == wpos_reg + POS_W'(1)) begin
            byte_sel = word_reg[BYTE_W-1:0];
        end else begin
            byte_sel = '0;
        end
    end

    always_comb begin
        fc_next   = fc_reg;
        wif_next  = wif_reg;
        busy_next = busy_reg;
        pos_next  = pos_reg;
        end_next  = end_reg;
        wpos_next = wpos_reg;
        word_next = word_reg;
        hdr_next  = hdr_reg;
        fnum_next = fnum_reg;
        if (emit) begin
            pos_next = pos_reg + POS_W'(1);
            if (finishing) begin
                busy_next = 1'b0;
            end
        end
        if (take) begin
            if (drop) begin
                busy_next = 1'b0;
                if (hold.item.last_word) begin
                    fc_next = '0;
                end
            end else begin
                busy_next = 1'b1;
                fc_next   = hold.item.last_word ? '0 : fc_item;
                wif_next  = closing ? '0 : wif_inc;
                pos_next  = open_frame ? POS_W'(0) : wpos;
                end_next  = closing ? LAST_POS : wpos + POS_W'(1);
                wpos_next = wpos;
                word_next = hold.item.word;
                hdr_next  = HDR_W'(fc_item);
                fnum_next = FNUM_W'(fc_item);
            end
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fc_reg       <= '0;
            wif_reg      <= '0;
            busy_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            fc_reg       <= fc_next;
            wif_reg      <= wif_next;
            busy_reg     <= busy_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        pos_reg  <= pos_next;
        end_reg  <= end_next;
        wpos_reg <= wpos_next;
        word_reg <= word_next;
        hdr_reg  <= hdr_next;
        fnum_reg <= fnum_next;
        if (emit) begin
            m_byte_reg  <= byte_sel;
            m_pos_reg   <= pos_reg;
            m_fnum_reg  <= fnum_reg;
            m_tlast_reg <= (pos_reg == LAST_POS);
            m_tuser_reg <= (pos_reg == end_reg);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, m_fnum_reg, m_pos_reg, m_byte_reg};
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    `WSCF_ASSERT_IMPL(a_pos_within_run, busy_reg, pos_reg <= end_reg)
    `WSCF_ASSERT_IMPL(a_wif_below_limit, 1'b1, wif_reg < WIF_W'(WORDS_PER_FRAME))
    `WSCF_ASSERT_IMPL(a_fc_within_limit, 1'b1, fc_reg <= FC_W'(MAX_FRAMES))
    `WSCF_ASSERT_NEXT(a_run_continues, emit && !finishing, busy_reg)

endmodule

### sv/word_stream_can_fd_framer.sv
// Top level of the word stream CAN-FD framer: cuts 16-bit words into 64-byte frame payloads.
// Depends on wscf_pkg, wscf_in_stage and wscf_byte_gen.
//
// Each accepted word puts out its bytes one per cycle through a byte-wide output register while
// the output side takes them, so a word inside an open frame gives 2 bytes, a word that opens a
// frame gives 4 (two header bytes carry the sequence number), and a word that closes a frame
// gives 64 minus its offset, up to 64 bytes including zero fill to byte 63. A word dropped past
// the frame limit gives no byte. The input register takes the next word while the current one is
// still being sent, so words follow without gaps as long as the output side keeps taking bytes.
module word_stream_can_fd_framer (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [wscf_pkg::WORD_W-1:0]  s_tdata,   // word
    input  logic                         s_tlast,   // last_word
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [23:0]                  m_tdata,   // frame_byte, byte_position, frame_number
    output logic                         m_tlast,   // frame_end
    output logic                         m_tuser    // run_end
);
    import wscf_pkg::*;

    hold_t hold;
    logic  take;

    wscf_in_stage u_in_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .hold     (hold),
        .take     (take)
    );

    wscf_byte_gen u_byte_gen (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .hold     (hold),
        .take     (take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

### dv/word_stream_can_fd_framer_test.sv
// Self-checking testbench of the word stream CAN-FD framer: drives words, predicts every payload
// byte with a local frame builder and compares each output item field by field.
// Depends on wscf_pkg and word_stream_can_fd_framer.
module word_stream_can_fd_framer_test;

    localparam int FC_W = wscf_pkg::FC_W;

    typedef struct packed {
        logic [wscf_pkg::BYTE_W-1:0] fbyte;
        logic [wscf_pkg::POS_W-1:0]  pos;
        logic [wscf_pkg::FNUM_W-1:0] fnum;
        logic                        fend;
        logic                        rend;
    } payload_byte_t;

    logic                        aclk;
    logic                        aresetn;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [wscf_pkg::WORD_W-1:0] s_tdata;
    logic                        s_tlast;
    logic                        m_tvalid;
    logic                        m_tready;
    logic [23:0]                 m_tdata;
    logic                        m_tlast;
    logic                        m_tuser;

    payload_byte_t payload_fifo[$];
    logic [FC_W-1:0] frames_started;
    int unsigned     words_held;
    int unsigned     error_count;
    int unsigned     hold_off_left;
    bit              no_idle;
    payload_byte_t   want;

    word_stream_can_fd_framer u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #12000000;
        $display("word_stream_can_fd_framer_test: errors");
        $finish;
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned wanted);
        $display("mismatch in %s: got 0x%0h, wanted 0x%0h at %0t", what, got, wanted, $time);
        error_count++;
    endtask

    function automatic void push_payload_byte(input logic [7:0] b, input int unsigned pos);
        payload_byte_t pb;
        pb.fbyte = b;
        pb.pos   = wscf_pkg::POS_W'(pos);
        pb.fnum  = wscf_pkg::FNUM_W'(frames_started);
        pb.fend  = (pos == wscf_pkg::PAYLOAD_BYTES - 1);
        pb.rend  = 1'b0;
        payload_fifo.push_back(pb);
    endfunction

    task automatic predict_payload(input logic [15:0] w, input logic last);
        logic [15:0]   seq;
        int unsigned   p;
        payload_byte_t tail;
        if (words_held == 0) begin
            if (frames_started >= wscf_pkg::MAX_FRAMES) begin
                if (last)
                    frames_started = '0;
                return;
            end
            frames_started = frames_started + 1'b1;
            seq = 16'(frames_started);
            push_payload_byte(seq[15:8], 0);
            push_payload_byte(seq[7:0], 1);
        end
        p = 2 + 2 * words_held;
        push_payload_byte(w[15:8], p);
        push_payload_byte(w[7:0], p + 1);
        words_held++;
        if (last || words_held >= wscf_pkg::WORDS_PER_FRAME) begin
            for (p = 2 + 2 * words_held; p < wscf_pkg::PAYLOAD_BYTES; p++)
                push_payload_byte(8'h00, p);
            words_held = 0;
            if (last)
                frames_started = '0;
        end
        tail = payload_fifo.pop_back();
        tail.rend = 1'b1;
        payload_fifo.push_back(tail);
    endtask

    task automatic send_word(input logic [15:0] w, input logic last);
        while (!no_idle && $urandom_range(99) < 32) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        s_tlast  <= last;
        @(negedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
            @(negedge aclk);
        end
        predict_payload(w, last);
        @(posedge aclk);
    endtask

    function automatic logic [15:0] random_word();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 5)
            return 16'h0000;
        else if (pick < 10)
            return 16'hFFFF;
        return 16'($urandom_range(0, 65535));
    endfunction

    always @(posedge aclk) begin
        if (hold_off_left > 0) begin
            m_tready <= 1'b0;
            hold_off_left--;
        end else if (!no_idle && $urandom_range(99) < 32) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(negedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (payload_fifo.size() == 0) begin
                report_mismatch("unexpected item", 32'(m_tdata), 0);
            end else begin
                want = payload_fifo.pop_front();
                if (m_tdata[7:0] !== want.fbyte)
                    report_mismatch("frame_byte", 32'(m_tdata[7:0]), 32'(want.fbyte));
                if (m_tdata[13:8] !== want.pos)
                    report_mismatch("byte_position", 32'(m_tdata[13:8]), 32'(want.pos));
                if (m_tdata[18:14] !== want.fnum)
                    report_mismatch("frame_number", 32'(m_tdata[18:14]), 32'(want.fnum));
                if (m_tdata[23:19] !== 5'd0)
                    report_mismatch("tdata padding", 32'(m_tdata[23:19]), 0);
                if (m_tlast !== want.fend)
                    report_mismatch("frame_end", 32'(m_tlast), 32'(want.fend));
                if (m_tuser !== want.rend)
                    report_mismatch("run_end", 32'(m_tuser), 32'(want.rend));
            end
        end
    end

    task automatic test_field_extremes();
        send_word(16'h0000, 1'b1);
        send_word(16'hFFFF, 1'b1);
        send_word(16'h8001, 1'b0);
        send_word(16'h7FFE, 1'b0);
        send_word(16'h00FF, 1'b1);
        send_word(16'hFF00, 1'b0);
        send_word(16'h1234, 1'b1);
    endtask

    // Fills every allowed frame of one buffer, then offers words past the limit; the marked
    // one among them must still restart the frame count.
    task automatic test_frame_limit();
        int unsigned k;
        for (k = 0; k < wscf_pkg::MAX_FRAMES * wscf_pkg::WORDS_PER_FRAME; k++)
            send_word(random_word(), 1'b0);
        send_word(16'hA5A5, 1'b0);
        send_word(16'hFFFF, 1'b0);
        send_word(16'h5A5A, 1'b1);
        send_word(16'hC3C3, 1'b1);
    endtask

    task automatic test_output_hold_off();
        int unsigned k;
        hold_off_left = 400;
        for (k = 0; k < 24; k++)
            send_word(random_word(), k == 23);
    endtask

    task automatic test_random_buffers(input int unsigned target);
        int unsigned sent;
        int unsigned len;
        int unsigned k;
        int unsigned pick;
        bit          marked;
        sent = 0;
        while (sent < target) begin
            pick = $urandom_range(99);
            if (pick < 15)
                len = wscf_pkg::WORDS_PER_FRAME * $urandom_range(1, 2) + $urandom_range(0, 2) - 1;
            else if (pick < 85)
                len = $urandom_range(1, 12);
            else
                len = $urandom_range(13, 70);
            marked = ($urandom_range(99) >= 10);
            for (k = 0; k < len; k++)
                send_word(random_word(), marked && (k == len - 1));
            sent += len;
        end
    endtask

    task automatic test_no_gaps();
        no_idle = 1'b1;
        test_random_buffers(30);
        no_idle = 1'b0;
    endtask

    initial begin
        aresetn       <= 1'b0;
        s_tvalid      <= 1'b0;
        s_tdata       <= '0;
        s_tlast       <= 1'b0;
        m_tready      <= 1'b0;
        frames_started = '0;
        words_held     = 0;
        error_count    = 0;
        hold_off_left  = 0;
        no_idle        = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_field_extremes();
        test_frame_limit();
        test_output_hold_off();
        test_random_buffers(40);
        test_no_gaps();

        s_tvalid <= 1'b0;
        while (payload_fifo.size() != 0)
            @(posedge aclk);
        repeat (80) @(posedge aclk);
        if (error_count == 0 && payload_fifo.size() == 0)
            $display("word_stream_can_fd_framer_test: clean");
        else
            $display("word_stream_can_fd_framer_test: errors");
        $finish;
    end

endmodule

### word_stream_can_fd_framer.f
+incdir+sv
sv/wscf_pkg.sv
sv/wscf_in_stage.sv
sv/wscf_byte_gen.sv
sv/word_stream_can_fd_framer.sv
dv/word_stream_can_fd_framer_test.sv
